// ===== sv/gcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Great-circle distance package
// Shared widths, fixed-point constants and helper functions for the
// great-circle distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

   localparam int CORDIC_ITERATIONS_DEF = 24;

   localparam int LAT_W    = 31;
   localparam int LON_W    = 32;
   localparam int RADIUS_W = 26;
   localparam int DIST_W   = 28;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 26'd6372795;

   // Angle reduction works on 1e-7 degree units.
   localparam int TURN_W = 34;
   localparam logic signed [TURN_W-1:0] FULL_TURN    = 34'sd3600000000;
   localparam logic signed [TURN_W-1:0] HALF_TURN    = 34'sd1800000000;
   localparam logic signed [TURN_W-1:0] QUARTER_TURN = 34'sd900000000;

   // Degree units to Q2.30 radians, scaled by 2^32.
   localparam logic [32:0] DEG_TO_RAD = 33'd8048910509;
   localparam int DTR_SPLIT = 17;
   localparam logic [32-DTR_SPLIT:0] DTR_HI = DEG_TO_RAD[32:DTR_SPLIT];
   localparam logic [DTR_SPLIT-1:0]  DTR_LO = DEG_TO_RAD[DTR_SPLIT-1:0];

   // Rotation and vectoring datapath widths.
   localparam int ROT_W = 34;
   localparam int VEC_W = 36;

   localparam logic signed [ROT_W-1:0] GAIN_Q30    = 34'sd652032874;
   localparam logic signed [ROT_W-1:0] ONE_Q30     = 34'sd1073741824;
   localparam logic signed [ROT_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [ROT_W-1:0] PI_Q30      = 34'sd3373259426;

   localparam int TRIG_W = 32;
   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic [31:0] angle_type;

   // Arctangent of 2^-i in Q2.30.
   function automatic logic [29:0] step_angle(input int i);
      logic [29:0] result;
      case (i)
         0:       result = 30'd843314856;
         1:       result = 30'd497837829;
         2:       result = 30'd263043836;
         3:       result = 30'd133525158;
         4:       result = 30'd67021686;
         5:       result = 30'd33543515;
         6:       result = 30'd16775850;
         7:       result = 30'd8388437;
         8:       result = 30'd4194282;
         9:       result = 30'd2097149;
         default: begin
            if (i > 30) begin
               result = '0;
            end else begin
               result = 30'(64'd1 << (30 - i));
            end
         end
      endcase
      return result;
   endfunction

   // Q1.30 product rounding, half away from zero on the magnitude.
   function automatic trig_type round_q30(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + 64'sd536870912 - $signed({63'd0, p[63]});
      return trig_type'(t[61:30]);
   endfunction

endpackage

// ===== sv/gcd_if.sv =====
// ----------------------------------------------------------------------------
// Great-circle distance channels
// Request, response and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface gcd_req_if
   import gcd_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic signed [LAT_W-1:0] near_latitude;
   logic signed [LON_W-1:0] near_longitude;
   logic signed [LAT_W-1:0] far_latitude;
   logic signed [LON_W-1:0] far_longitude;

   modport source (output valid, near_latitude, near_longitude, far_latitude,
                   far_longitude, input ready);
   modport sink (input valid, near_latitude, near_longitude, far_latitude,
                 far_longitude, output ready);
endinterface

interface gcd_rsp_if
   import gcd_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance_m;

   modport source (output valid, distance_m, input ready);
   modport sink (input valid, distance_m, output ready);
endinterface

interface gcd_csr_if
   import gcd_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [RADIUS_W-1:0] sphere_radius_m;

   modport source (output valid, sphere_radius_m, input ready);
   modport sink (input valid, sphere_radius_m, output ready);
endinterface

// ===== sv/great_circle_distance.sv =====
// ----------------------------------------------------------------------------
// Great-circle distance
// Distance between two positions on a sphere of programmable radius, using
// the spherical Vincenty form of the central angle.
// ----------------------------------------------------------------------------
// The block takes one request per clock and returns one distance per request,
// in request order. The pipeline depth is set by the fully unrolled CORDIC
// rotation and vectoring pipelines and the 32-stage square root. A response
// held by the sink does not stop intake at once: an output register and one
// spare entry absorb it, and only then does the pipeline hold. The radius
// register is read at the last multiply, so write it only while no request
// is in flight.
module great_circle_distance
   import gcd_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   gcd_req_if.sink   req_if,
   gcd_rsp_if.source rsp_if,
   gcd_csr_if.sink   csr_if
);

   logic                    en;
   logic                    take;
   logic [RADIUS_W-1:0]     radius_ff;

   logic                    in_v_ff;
   logic signed [TURN_W-1:0] dlon_ff, lat1_ff, lat2_ff;

   logic                    sd_v, s1_v, s2_v, sc_v;
   trig_type                sd, cd, s1, c1, s2, c2;

   logic [7:0]              t_v_ff;
   logic signed [63:0]      m_c1s2_ff, m_s1c2_ff, m_s1s2_ff, m_c1c2_ff, m_c2sd_ff;
   trig_type                cd0_ff, cd1_ff;
   trig_type                r_c1s2_ff, r_s1c2_ff, r_s1s2_ff, r_c1c2_ff, r_c2sd_ff;
   logic signed [63:0]      m_acd_ff, m_dcd_ff;
   trig_type                k_c1s2_ff, k_s1s2_ff, k_c2sd_ff;
   trig_type                r_acd_ff, r_dcd_ff;
   trig_type                j_c1s2_ff, j_s1s2_ff, j_c2sd_ff;
   logic signed [ROT_W-1:0] num_a_ff, num_b_ff;
   logic signed [ROT_W-1:0] den4_ff, den5_ff, den6_ff, den7_ff;
   logic [31:0]             mag_a_ff, mag_b_ff;
   logic [63:0]             sq_a_ff, sq_b_ff, sum_sq_ff;

   logic                    ang_v;
   angle_type               ang;
   logic [1:0]              d_v_ff;
   logic [57:0]             prod_ff;
   logic [57:0]             prod_rnd;
   logic [DIST_W-1:0]       dist_ff;

   logic                    out_v_ff, skid_v_ff;
   logic [DIST_W-1:0]       out_d_ff, skid_d_ff;

   function automatic logic [31:0] mag_clip(input logic signed [ROT_W-1:0] v);
      logic signed [ROT_W-1:0] m;
      m = v[ROT_W-1] ? -v : v;
      return (m > 34'sd2147483648) ? 32'h8000_0000 : 32'(m);
   endfunction

   // The pipeline moves whenever the spare output entry is free.
   assign en           = ~skid_v_ff;
   assign req_if.ready = en;
   assign csr_if.ready = 1'b1;
   assign take         = rsp_if.valid & rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_if.valid) begin
         radius_ff <= csr_if.sphere_radius_m;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (en) begin
         in_v_ff <= req_if.valid;
      end
      if (en) begin
         dlon_ff <= TURN_W'(req_if.near_longitude) - TURN_W'(req_if.far_longitude);
         lat1_ff <= TURN_W'(req_if.near_latitude);
         lat2_ff <= TURN_W'(req_if.far_latitude);
      end
   end

   gcd_sincos #(.ITERATIONS(CORDIC_ITERATIONS)) u_sc_dlon (
      .clock, .reset, .en, .in_valid(in_v_ff), .angle(dlon_ff),
      .out_valid(sd_v), .sin_q(sd), .cos_q(cd)
   );

   gcd_sincos #(.ITERATIONS(CORDIC_ITERATIONS)) u_sc_lat1 (
      .clock, .reset, .en, .in_valid(in_v_ff), .angle(lat1_ff),
      .out_valid(s1_v), .sin_q(s1), .cos_q(c1)
   );

   gcd_sincos #(.ITERATIONS(CORDIC_ITERATIONS)) u_sc_lat2 (
      .clock, .reset, .en, .in_valid(in_v_ff), .angle(lat2_ff),
      .out_valid(s2_v), .sin_q(s2), .cos_q(c2)
   );

   assign sc_v = sd_v & s1_v & s2_v;

   // Products of the trig terms, the numerator legs and the denominator, and the sum of the squared legs.
   always_ff @(posedge clock) begin
      if (reset) begin
         t_v_ff <= '0;
      end else if (en) begin
         t_v_ff <= {t_v_ff[6:0], sc_v};
      end
      if (en) begin
         m_c1s2_ff <= c1 * s2;
         m_s1c2_ff <= s1 * c2;
         m_s1s2_ff <= s1 * s2;
         m_c1c2_ff <= c1 * c2;
         m_c2sd_ff <= c2 * sd;
         cd0_ff    <= cd;

         r_c1s2_ff <= round_q30(m_c1s2_ff);
         r_s1c2_ff <= round_q30(m_s1c2_ff);
         r_s1s2_ff <= round_q30(m_s1s2_ff);
         r_c1c2_ff <= round_q30(m_c1c2_ff);
         r_c2sd_ff <= round_q30(m_c2sd_ff);
         cd1_ff    <= cd0_ff;

         m_acd_ff  <= r_s1c2_ff * cd1_ff;
         m_dcd_ff  <= r_c1c2_ff * cd1_ff;
         k_c1s2_ff <= r_c1s2_ff;
         k_s1s2_ff <= r_s1s2_ff;
         k_c2sd_ff <= r_c2sd_ff;

         r_acd_ff  <= round_q30(m_acd_ff);
         r_dcd_ff  <= round_q30(m_dcd_ff);
         j_c1s2_ff <= k_c1s2_ff;
         j_s1s2_ff <= k_s1s2_ff;
         j_c2sd_ff <= k_c2sd_ff;

         num_a_ff  <= ROT_W'(j_c1s2_ff) - ROT_W'(r_acd_ff);
         num_b_ff  <= ROT_W'(j_c2sd_ff);
         den4_ff   <= ROT_W'(j_s1s2_ff) + ROT_W'(r_dcd_ff);

         mag_a_ff  <= mag_clip(num_a_ff);
         mag_b_ff  <= mag_clip(num_b_ff);
         den5_ff   <= den4_ff;

         sq_a_ff   <= mag_a_ff * mag_a_ff;
         sq_b_ff   <= mag_b_ff * mag_b_ff;
         den6_ff   <= den5_ff;

         sum_sq_ff <= sq_a_ff + sq_b_ff;
         den7_ff   <= den6_ff;
      end
   end

   gcd_angle #(.ITERATIONS(CORDIC_ITERATIONS)) u_angle (
      .clock, .reset, .en, .in_valid(t_v_ff[7]), .sum_sq(sum_sq_ff), .den(den7_ff),
      .out_valid(ang_v), .angle(ang)
   );

   assign prod_rnd = prod_ff + (58'd1 << 29);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= '0;
      end else if (en) begin
         d_v_ff <= {d_v_ff[0], ang_v};
      end
      if (en) begin
         prod_ff <= ang * radius_ff;
         dist_ff <= prod_rnd[57:30];
      end
   end

   // Output register with one spare entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (take) begin
            out_d_ff  <= skid_d_ff;
            skid_v_ff <= 1'b0;
         end
      end else if (d_v_ff[1]) begin
         if (!out_v_ff || take) begin
            out_v_ff <= 1'b1;
            out_d_ff <= dist_ff;
         end else begin
            skid_v_ff <= 1'b1;
            skid_d_ff <= dist_ff;
         end
      end else if (take) begin
         out_v_ff <= 1'b0;
      end
   end

   assign rsp_if.valid      = out_v_ff;
   assign rsp_if.distance_m = out_d_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("spare entry holds a response while the output register is empty");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && d_v_ff[1] && !rsp_if.ready))
      else $error("spare entry filled without a blocked output");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      ang_v |-> ang <= angle_type'(PI_Q30))
      else $error("central angle above pi");

endmodule

// ===== sv/gcd_sincos.sv =====
// ----------------------------------------------------------------------------
// Pipelined sine and cosine
// Reduces an angle in 1e-7 degree units to the first quadrant, converts it to
// Q2.30 radians and rotates with one CORDIC step per stage.
// ----------------------------------------------------------------------------
module gcd_sincos
   import gcd_pkg::*;
#(
   parameter int ITERATIONS = CORDIC_ITERATIONS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic signed [TURN_W-1:0] angle,
   output logic                     out_valid,
   output trig_type                 sin_q,
   output trig_type                 cos_q
);

   localparam int LATENCY = ITERATIONS + 7;

   typedef struct packed {
      logic signed [ROT_W-1:0] x;
      logic signed [ROT_W-1:0] y;
      logic signed [ROT_W-1:0] z;
      logic                    neg;
      logic                    flip;
      logic                    zero;
   } rot_type;

   logic [LATENCY-1:0]        vld_ff;
   logic signed [TURN_W-1:0]  wrap_ff, wrap_in;
   logic signed [31:0]        half_ff, half_in;
   logic [30:0]               mag_ff;
   logic                      neg_mag_ff;
   logic [29:0]               fold_ff;
   logic                      neg_fold_ff, flip_fold_ff;
   logic [45:0]               prod_hi_ff;
   logic [46:0]               prod_lo_ff;
   logic                      neg_prod_ff, flip_prod_ff, zero_prod_ff;
   logic [63:0]               z_sum;
   rot_type                   rot_ff [ITERATIONS+1];
   rot_type                   rot_in [ITERATIONS+1];
   trig_type                  sin_ff, sin_in, cos_ff, cos_in;

   function automatic trig_type clamp_unit(input logic signed [ROT_W-1:0] v);
      trig_type result;
      if (v > ONE_Q30) begin
         result = trig_type'(ONE_Q30);
      end else if (v < -ONE_Q30) begin
         result = trig_type'(-ONE_Q30);
      end else begin
         result = trig_type'(v);
      end
      return result;
   endfunction

   // Truncating remainder by a full turn, then wrap into [-180, 180).
   always_comb begin
      if (angle >= FULL_TURN) begin
         wrap_in = angle - FULL_TURN;
      end else if (angle <= -FULL_TURN) begin
         wrap_in = angle + FULL_TURN;
      end else begin
         wrap_in = angle;
      end
      if (wrap_ff >= HALF_TURN) begin
         half_in = 32'(wrap_ff - FULL_TURN);
      end else if (wrap_ff < -HALF_TURN) begin
         half_in = 32'(wrap_ff + FULL_TURN);
      end else begin
         half_in = 32'(wrap_ff);
      end
   end

   always_comb begin
      z_sum = (64'(prod_hi_ff) << DTR_SPLIT) + 64'(prod_lo_ff) + 64'h8000_0000;
      rot_in[0].x    = GAIN_Q30;
      rot_in[0].y    = '0;
      rot_in[0].z    = $signed({3'b000, z_sum[62:32]});
      rot_in[0].neg  = neg_prod_ff;
      rot_in[0].flip = flip_prod_ff;
      rot_in[0].zero = zero_prod_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wrap_ff      <= wrap_in;
         half_ff      <= half_in;
         neg_mag_ff   <= half_ff[31];
         mag_ff       <= half_ff[31] ? 31'(-half_ff) : 31'(half_ff);
         neg_fold_ff  <= neg_mag_ff;
         flip_fold_ff <= mag_ff > 31'(QUARTER_TURN);
         fold_ff      <= (mag_ff > 31'(QUARTER_TURN)) ? 30'(31'(HALF_TURN) - mag_ff)
                                                      : 30'(mag_ff);
         prod_hi_ff   <= fold_ff * DTR_HI;
         prod_lo_ff   <= fold_ff * DTR_LO;
         neg_prod_ff  <= neg_fold_ff;
         flip_prod_ff <= flip_fold_ff;
         zero_prod_ff <= fold_ff == '0;
         rot_ff[0]    <= rot_in[0];
      end
   end

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
      localparam logic signed [ROT_W-1:0] STEP = ROT_W'(step_angle(i));

      always_comb begin
         rot_in[i+1] = rot_ff[i];
         if (!rot_ff[i].z[ROT_W-1]) begin
            rot_in[i+1].x = $signed(rot_ff[i].x) - ($signed(rot_ff[i].y) >>> i);
            rot_in[i+1].y = $signed(rot_ff[i].y) + ($signed(rot_ff[i].x) >>> i);
            rot_in[i+1].z = $signed(rot_ff[i].z) - STEP;
         end else begin
            rot_in[i+1].x = $signed(rot_ff[i].x) + ($signed(rot_ff[i].y) >>> i);
            rot_in[i+1].y = $signed(rot_ff[i].y) - ($signed(rot_ff[i].x) >>> i);
            rot_in[i+1].z = $signed(rot_ff[i].z) + STEP;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rot_ff[i+1] <= rot_in[i+1];
         end
      end
   end

   // A folded angle of zero gives exact sin = 0 and cos = 1, or cos = -1 when folded from 180 degrees.
   always_comb begin
      trig_type xc, yc;
      xc = clamp_unit(rot_ff[ITERATIONS].x);
      yc = clamp_unit(rot_ff[ITERATIONS].y);
      if (rot_ff[ITERATIONS].zero) begin
         xc = trig_type'(ONE_Q30);
         yc = '0;
      end
      sin_in = rot_ff[ITERATIONS].neg  ? -yc : yc;
      cos_in = rot_ff[ITERATIONS].flip ? -xc : xc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LATENCY-2:0], in_valid};
      end
      if (en) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign out_valid = vld_ff[LATENCY-1];
   assign sin_q     = sin_ff;
   assign cos_q     = cos_ff;

endmodule

// ===== sv/gcd_angle.sv =====
// ----------------------------------------------------------------------------
// Pipelined central angle
// Square root of the numerator's sum of squares, one result bit per stage,
// followed by a CORDIC vectoring pipeline that yields atan2 in unsigned Q2.30.
// ----------------------------------------------------------------------------
module gcd_angle
   import gcd_pkg::*;
#(
   parameter int ITERATIONS = CORDIC_ITERATIONS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [63:0]             sum_sq,
   input  logic signed [ROT_W-1:0] den,
   output logic                    out_valid,
   output angle_type               angle
);

   localparam int SQRT_STEPS = 32;
   localparam int LATENCY    = SQRT_STEPS + ITERATIONS + 2;

   typedef struct packed {
      logic [63:0]             rem;
      logic [63:0]             root;
      logic signed [ROT_W-1:0] den;
   } sqrt_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ROT_W-1:0] z;
   } vec_type;

   logic [LATENCY-1:0] vld_ff;
   sqrt_type           sq_ff [SQRT_STEPS];
   sqrt_type           sq_in [SQRT_STEPS];
   vec_type            vec_ff [ITERATIONS+1];
   vec_type            vec_in [ITERATIONS+1];
   angle_type          angle_ff, angle_in;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [63:0] BIT_K = 64'd1 << (62 - 2 * k);
      sqrt_type src;
      logic [63:0] trial;

      if (k == 0) begin : g_first
         assign src = '{rem: sum_sq, root: '0, den: den};
      end else begin : g_next
         assign src = sq_ff[k-1];
      end

      always_comb begin
         trial    = src.root + BIT_K;
         sq_in[k] = src;
         if (src.rem >= trial) begin
            sq_in[k].rem  = src.rem - trial;
            sq_in[k].root = (src.root >> 1) + BIT_K;
         end else begin
            sq_in[k].root = src.root >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[k] <= sq_in[k];
         end
      end
   end

   // A negative denominator is turned by -90 degrees first.
   always_comb begin
      logic signed [VEC_W-1:0] hyp;
      hyp = $signed({4'b0000, sq_ff[SQRT_STEPS-1].root[31:0]});
      if (sq_ff[SQRT_STEPS-1].den[ROT_W-1]) begin
         vec_in[0].x = hyp;
         vec_in[0].y = -VEC_W'(sq_ff[SQRT_STEPS-1].den);
         vec_in[0].z = HALF_PI_Q30;
      end else begin
         vec_in[0].x = VEC_W'(sq_ff[SQRT_STEPS-1].den);
         vec_in[0].y = hyp;
         vec_in[0].z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff[0] <= vec_in[0];
      end
   end

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_vec
      localparam logic signed [ROT_W-1:0] STEP = ROT_W'(step_angle(i));

      always_comb begin
         vec_in[i+1] = vec_ff[i];
         if ($signed(vec_ff[i].y) > 0) begin
            vec_in[i+1].x = $signed(vec_ff[i].x) + ($signed(vec_ff[i].y) >>> i);
            vec_in[i+1].y = $signed(vec_ff[i].y) - ($signed(vec_ff[i].x) >>> i);
            vec_in[i+1].z = $signed(vec_ff[i].z) + STEP;
         end else if ($signed(vec_ff[i].y) < 0) begin
            vec_in[i+1].x = $signed(vec_ff[i].x) - ($signed(vec_ff[i].y) >>> i);
            vec_in[i+1].y = $signed(vec_ff[i].y) + ($signed(vec_ff[i].x) >>> i);
            vec_in[i+1].z = $signed(vec_ff[i].z) - STEP;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            vec_ff[i+1] <= vec_in[i+1];
         end
      end
   end

   always_comb begin
      if (vec_ff[ITERATIONS].z[ROT_W-1]) begin
         angle_in = '0;
      end else if ($signed(vec_ff[ITERATIONS].z) > PI_Q30) begin
         angle_in = angle_type'(PI_Q30);
      end else begin
         angle_in = angle_type'(vec_ff[ITERATIONS].z);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LATENCY-2:0], in_valid};
      end
      if (en) begin
         angle_ff <= angle_in;
      end
   end

   assign out_valid = vld_ff[LATENCY-1];
   assign angle     = angle_ff;

endmodule
